>>> rtl/hed_pkg.sv
// Shared types, entity tables and helpers for the HTML entity decoder.
`default_nettype none

package hed_pkg;

    // Fixed widths of the stream payloads
    localparam int CHAR_W      = 16;
    localparam int CONV_W      = 16;

    // Look-ahead and entity table sizes
    localparam int LOOK_DEPTH  = 7;
    localparam int NUM_ENT     = 9;
    localparam int FILL_W      = 3;
    localparam int SEQ_W       = 4;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Defaults for the top-level parameters
    localparam int DEF_CHAR_BITS  = 16;
    localparam int DEF_COUNT_BITS = 16;

    localparam logic [CHAR_W-1:0] AMP_CHAR = 16'h0026;

    // Input transfer
    typedef struct packed {
        logic              kind;
        logic [CHAR_W-1:0] in_char;
    } item_t;

    // Output transfer
    typedef struct packed {
        logic [CHAR_W-1:0] out_char;
        logic              is_end;
        logic [CONV_W-1:0] conversions;
        logic              last_of_run;
    } result_t;

    // What closes a job's output sequence
    typedef enum logic [1:0] {
        TAIL_NONE,
        TAIL_CHAR,
        TAIL_END
    } tail_t;

    // One classified item: optional '&', buffered chars, then the tail
    typedef struct packed {
        logic                               amp;
        logic [FILL_W-1:0]                  nbuf;
        logic [LOOK_DEPTH-1:0][CHAR_W-1:0]  chars;
        tail_t                              tail;
        logic [CHAR_W-1:0]                  tail_char;
        logic [CONV_W-1:0]                  count;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Entity names after the '&', lowercase, zero padded
    localparam logic [7:0] ENT_NAME [NUM_ENT][LOOK_DEPTH] = '{
        '{"q", "u", "o", "t", ";", 8'h00, 8'h00},
        '{"a", "m", "p", ";", 8'h00, 8'h00, 8'h00},
        '{"n", "d", "a", "s", "h", ";", 8'h00},
        '{"e", "a", "c", "u", "t", "e", ";"},
        '{"l", "t", ";", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"g", "t", ";", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"#", "3", "9", ";", 8'h00, 8'h00, 8'h00},
        '{"#", "1", "8", "0", ";", 8'h00, 8'h00},
        '{"a", "c", "u", "t", "e", ";", 8'h00}
    };

    localparam logic [FILL_W-1:0] ENT_LEN [NUM_ENT] = '{
        3'd5, 3'd4, 3'd6, 3'd7, 3'd3, 3'd3, 3'd4, 3'd5, 3'd6
    };

    localparam logic [CHAR_W-1:0] ENT_REPL [NUM_ENT] = '{
        16'h0022, 16'h0026, 16'h002D, 16'h00E9, 16'h003C,
        16'h003E, 16'h0027, 16'h00B4, 16'h00B4
    };

    // ASCII-only lowercase fold
    function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 16'h0041 && c <= 16'h005A)
        begin
            r = c + 16'h0020;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> rtl/hed_front.sv
// Front end: accepts characters, tracks entity matches, issues output jobs.
`default_nettype none

module hed_front #(
    parameter int CHAR_BITS  = hed_pkg::DEF_CHAR_BITS,
    parameter int COUNT_BITS = hed_pkg::DEF_COUNT_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire hed_pkg::item_t    item,
    input  wire hed_pkg::q_status_t q_status,
    output logic                   push,
    output hed_pkg::job_t          job
);

    localparam logic [31:0] CHAR_MASK32 =
        (CHAR_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << CHAR_BITS) - 32'd1);
    localparam logic [hed_pkg::CHAR_W-1:0] CHAR_MASK = CHAR_MASK32[hed_pkg::CHAR_W-1:0];
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic [hed_pkg::CHAR_W-1:0]  look_reg [hed_pkg::LOOK_DEPTH];
    logic [hed_pkg::FILL_W-1:0]  fill_reg, fill_next;
    logic                        in_ent_reg, in_ent_next;
    logic [hed_pkg::NUM_ENT-1:0] alive_reg, alive_next;
    logic [COUNT_BITS-1:0]       count_reg, count_next;

    logic                        accept;
    logic [hed_pkg::CHAR_W-1:0]  c;
    logic [hed_pkg::CHAR_W-1:0]  c_fold;
    logic [hed_pkg::FILL_W-1:0]  pos_p1;
    logic [hed_pkg::NUM_ENT-1:0] hit;
    logic [hed_pkg::NUM_ENT-1:0] full;
    logic                        partial;
    logic [hed_pkg::CHAR_W-1:0]  repl;
    logic [31:0]                 count32;

    assign item_stall = q_status.full;
    assign accept     = item_valid && !q_status.full;
    assign c          = item.in_char & CHAR_MASK;
    assign c_fold     = hed_pkg::fold_char(c);
    assign pos_p1     = fill_reg + 3'd1;
    assign count32    = 32'(count_reg);

    // Per-entity match of the new character at the current position
    always_comb
    begin
        for (int i = 0; i < hed_pkg::NUM_ENT; i++)
        begin
            hit[i]  = alive_reg[i] && (fill_reg < hed_pkg::ENT_LEN[i]) &&
                      (c_fold == {8'h00, hed_pkg::ENT_NAME[i][fill_reg]});
            full[i] = hit[i] && (pos_p1 == hed_pkg::ENT_LEN[i]);
        end
        partial = |(hit & ~full);
        repl    = '0;
        for (int i = hed_pkg::NUM_ENT - 1; i >= 0; i--)
        begin
            if (full[i])
            begin
                repl = hed_pkg::ENT_REPL[i];
            end
        end
    end

    // Classification and job build
    always_comb
    begin
        fill_next     = fill_reg;
        in_ent_next   = in_ent_reg;
        alive_next    = alive_reg;
        count_next    = count_reg;
        push          = 1'b0;
        job.amp       = 1'b0;
        job.nbuf      = '0;
        for (int j = 0; j < hed_pkg::LOOK_DEPTH; j++)
        begin
            job.chars[j] = look_reg[j];
        end
        job.tail      = hed_pkg::TAIL_CHAR;
        job.tail_char = c;
        job.count     = count32[hed_pkg::CONV_W-1:0];

        if (accept)
        begin
            if (item.kind)
            begin
                // end of text: flush pending text, then the marker
                push        = 1'b1;
                job.amp     = in_ent_reg;
                job.nbuf    = in_ent_reg ? fill_reg : '0;
                job.tail    = hed_pkg::TAIL_END;
                in_ent_next = 1'b0;
                fill_next   = '0;
                count_next  = '0;
            end
            else if (!in_ent_reg)
            begin
                if (c == hed_pkg::AMP_CHAR)
                begin
                    in_ent_next = 1'b1;
                    fill_next   = '0;
                    alive_next  = '1;
                end
                else
                begin
                    push = 1'b1;
                end
            end
            else if (|full)
            begin
                push          = 1'b1;
                job.tail_char = repl;
                in_ent_next   = 1'b0;
                fill_next     = '0;
                if (count_reg != COUNT_MAX)
                begin
                    count_next = count_reg + 1'b1;
                end
            end
            else if (partial)
            begin
                fill_next  = pos_p1;
                alive_next = hit;
            end
            else
            begin
                // no entity can match: '&', buffered text, breaking char
                push        = 1'b1;
                job.amp     = 1'b1;
                job.nbuf    = fill_reg;
                in_ent_next = (c == hed_pkg::AMP_CHAR);
                fill_next   = '0;
                alive_next  = '1;
                if (c == hed_pkg::AMP_CHAR)
                begin
                    job.tail = hed_pkg::TAIL_NONE;
                end
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg   <= '0;
            in_ent_reg <= 1'b0;
            alive_reg  <= '1;
            count_reg  <= '0;
        end
        else
        begin
            fill_reg   <= fill_next;
            in_ent_reg <= in_ent_next;
            alive_reg  <= alive_next;
            count_reg  <= count_next;
        end
    end

    // Look-ahead buffer
    always_ff @(posedge clk)
    begin
        if (accept && !item.kind && in_ent_reg)
        begin
            look_reg[fill_reg] <= c;
        end
    end

endmodule

`default_nettype wire

>>> rtl/hed_queue.sv
// Small job FIFO between the front and back ends.
`default_nettype none

module hed_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire hed_pkg::job_t      push_job,
    input  wire logic               pop,
    output hed_pkg::q_status_t      q_status,
    output hed_pkg::job_t           head_job
);

    localparam int PTR_W = (hed_pkg::QUEUE_DEPTH > 1) ? $clog2(hed_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(hed_pkg::QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(hed_pkg::QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(hed_pkg::QUEUE_DEPTH);

    hed_pkg::job_t    entry_reg [hed_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign q_status.full  = (cnt_reg == FULL_CNT);
    assign q_status.empty = (cnt_reg == '0);
    assign head_job       = entry_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> rtl/hed_back.sv
// Back end: walks the head job one result per cycle, while not stalled, into the output register.
`default_nettype none

module hed_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire hed_pkg::q_status_t q_status,
    input  wire hed_pkg::job_t      job,
    output logic                    pop,
    output logic                    result_valid,
    input  wire logic               result_stall,
    output hed_pkg::result_t        result
);

    logic [hed_pkg::SEQ_W-1:0] idx_reg, idx_next;
    logic                      valid_reg, valid_next;
    hed_pkg::result_t          result_reg;

    logic [hed_pkg::SEQ_W-1:0] seq_len;
    logic [hed_pkg::SEQ_W-1:0] buf_idx;
    logic                      load;
    logic                      last;
    logic                      at_tail;
    logic [hed_pkg::CHAR_W-1:0] ch;
    hed_pkg::result_t          elem;

    assign result_valid = valid_reg;
    assign result       = result_reg;

    // Pick the element at the current step of the job
    always_comb
    begin
        seq_len = {3'b000, job.amp} + {1'b0, job.nbuf} +
                  {3'b000, (job.tail != hed_pkg::TAIL_NONE)};
        buf_idx = idx_reg - {3'b000, job.amp};
        at_tail = 1'b0;
        if (job.amp && idx_reg == '0)
        begin
            ch = hed_pkg::AMP_CHAR;
        end
        else if (buf_idx < {1'b0, job.nbuf})
        begin
            ch = job.chars[buf_idx[hed_pkg::FILL_W-1:0]];
        end
        else
        begin
            ch      = job.tail_char;
            at_tail = 1'b1;
        end

        last = ((idx_reg + 4'd1) == seq_len);
        load = !q_status.empty && (!valid_reg || !result_stall);
        pop  = load && last;

        elem.is_end      = at_tail && (job.tail == hed_pkg::TAIL_END);
        elem.out_char    = elem.is_end ? '0 : ch;
        elem.conversions = elem.is_end ? job.count : '0;
        elem.last_of_run = last;

        idx_next   = idx_reg;
        valid_next = valid_reg && result_stall;
        if (load)
        begin
            idx_next   = last ? '0 : idx_reg + 4'd1;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= elem;
        end
    end

endmodule

`default_nettype wire

>>> rtl/html_entity_decoder.sv
// Top level of the streaming HTML entity decoder.
//
//  channel | dir | handshake            | payload
//  --------+-----+----------------------+------------------------------
//  item    | in  | item_valid/item_stall| kind, in_char
//  result  | out | result_valid/        | out_char, is_end, conversions,
//          |     |   result_stall       |   last_of_run
//
// One input transfer per cycle while the two-entry job queue has room.
// The back end delivers one result per cycle while not stalled; an item producing
// k results (at most 8) holds it until all are sent, so sustained rate is set by that unit.
// Results leave through a registered output, behind the registered job queue.
// Reset clears match state, count, queue and output valid; no clearing pass.
// A stalled result holds the back end; the front end stalls once the queue fills.
`default_nettype none

module html_entity_decoder #(
    parameter int CHAR_BITS  = hed_pkg::DEF_CHAR_BITS,
    parameter int COUNT_BITS = hed_pkg::DEF_COUNT_BITS
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_stall,
    input  wire hed_pkg::item_t    item,
    output logic                   result_valid,
    input  wire logic              result_stall,
    output hed_pkg::result_t       result
);

    hed_pkg::q_status_t q_status;
    hed_pkg::job_t      push_job;
    hed_pkg::job_t      head_job;
    logic               push;
    logic               pop;

    hed_front #(
        .CHAR_BITS  (CHAR_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .item       (item),
        .q_status   (q_status),
        .push       (push),
        .job        (push_job)
    );

    hed_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .q_status (q_status),
        .head_job (head_job)
    );

    hed_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_status     (q_status),
        .job          (head_job),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    // Queue never written when full nor read when empty
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_status.full)
        else $error("job pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_status.empty)
        else $error("job popped from empty queue");

    // End marker closes its run and carries no character
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.is_end) |-> (result.last_of_run && result.out_char == '0))
        else $error("end marker not last or carries a character");

    // Character results carry no count
    a_char_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.is_end) |-> (result.conversions == '0))
        else $error("count on a character result");

endmodule

`default_nettype wire
